// ----- hdl/signed_int_to_decimal_ascii_macros.svh -----
// Assertion macros shared by the signed integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Checked on every clock edge outside reset.
`define S2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define S2D_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/s2d_pkg.sv -----
// Package with constants, types and state encodings of the decimal text converter.
package s2d_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int MAG_W         = VALUE_WIDTH;
  localparam int NUM_DIGITS    = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 3;
  localparam int NUM_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SR_W          = NUM_STEPS * BITS_PER_STEP;
  localparam int ACC_W         = BCD_W + SR_W;
  localparam int STEP_CNT_W    = $clog2(NUM_STEPS);
  localparam int DIG_CNT_W     = $clog2(NUM_DIGITS);
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } mag_item_t;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } bcd_item_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGITS
  } emit_state_t;

endpackage

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal ASCII text converter.
// Usage:
// The input side is a queue: an item is taken on a clock edge where in_push
// is high and in_full is low. Each item is one signed integer, in_value.
// The result side is a queue too: while out_empty is low the oldest
// character stands on out_character with out_last, and it is taken on an
// edge where out_pop is high. Each number yields a minus sign if negative,
// then its decimal digits most significant first without leading zeros;
// zero gives a single '0'. out_last marks the final character of a number.
// Two items wait in a queue ahead of the converter, which runs its
// shift-and-add-three steps on one number at a time and takes the next
// only as it hands the last to the emitter; it sets the sustained rate.
// The emitter gives out at most one character per cycle and drops each
// leading zero in a step of its own that needs no room in its output
// register. With every stage idle, a negative number or one with ten
// digits shows its first character soonest, a single digit latest. When the
// receiver stops popping, the emitter, converter and queue fill in turn and
// in_full rises; nothing is lost. A synchronous reset empties every stage
// at once.
module signed_int_to_decimal_ascii (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  input  logic signed [s2d_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                   in_full,
  input  logic                                   out_pop,
  output logic                                   out_empty,
  output logic [s2d_pkg::CHAR_W-1:0]             out_character,
  output logic                                   out_last
);
  import s2d_pkg::*;

  logic      fifo_full;
  logic      wr_en;
  mag_item_t wr_item;
  logic      rd_en;
  logic      rd_valid;
  mag_item_t rd_item;
  logic      conv_valid;
  bcd_item_t conv_item;
  logic      emit_ready;

  s2d_front u_front (
    .in_push   (in_push),
    .in_value  (in_value),
    .in_full   (in_full),
    .fifo_full (fifo_full),
    .wr_en     (wr_en),
    .wr_item   (wr_item)
  );

  s2d_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_item  (wr_item),
    .full     (fifo_full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_item  (rd_item)
  );

  s2d_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_valid),
    .in_item   (rd_item),
    .rd_en     (rd_en),
    .out_valid (conv_valid),
    .out_item  (conv_item),
    .out_ready (emit_ready)
  );

  s2d_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (conv_valid),
    .in_item       (conv_item),
    .in_ready      (emit_ready),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ----- hdl/s2d_front.sv -----
// Input stage: takes each integer and splits it into sign and unsigned magnitude.
module s2d_front (
  input  logic                                 in_push,
  input  logic signed [s2d_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                 in_full,
  input  logic                                 fifo_full,
  output logic                                 wr_en,
  output s2d_pkg::mag_item_t                   wr_item
);
  import s2d_pkg::*;

  logic [MAG_W-1:0] raw;
  logic             neg;

  assign raw     = MAG_W'(in_value);
  assign neg     = raw[MAG_W-1];
  assign in_full = fifo_full;
  assign wr_en   = in_push && !fifo_full;

  // Negating in a width of exactly VALUE_WIDTH bits yields the right unsigned
  // magnitude for the most negative value too.
  assign wr_item.neg = neg;
  assign wr_item.mag = neg ? ((~raw) + MAG_W'(1)) : raw;

endmodule

// ----- hdl/s2d_fifo.sv -----
// Short queue that decouples the input stage from the converter.
`include "signed_int_to_decimal_ascii_macros.svh"

module s2d_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  s2d_pkg::mag_item_t wr_item,
  output logic               full,
  input  logic               rd_en,
  output logic               rd_valid,
  output s2d_pkg::mag_item_t rd_item
);
  import s2d_pkg::*;

  mag_item_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;

  assign full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `S2D_ASSERT(a_fifo_no_read_empty, rd_en |-> (count_r != '0), "Queue read while empty.")
  `S2D_ASSERT(a_fifo_fill, (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1), "Queue fill count did not rise.")

endmodule

// ----- hdl/s2d_conv.sv -----
// Binary to BCD converter using shift-and-add-three, three bits (BITS_PER_STEP) per step.
`include "signed_int_to_decimal_ascii_macros.svh"

module s2d_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  s2d_pkg::mag_item_t in_item,
  output logic               rd_en,
  output logic               out_valid,
  output s2d_pkg::bcd_item_t out_item,
  input  logic               out_ready
);
  import s2d_pkg::*;

  conv_state_t           state_r, state_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  take;

  function automatic logic [ACC_W-1:0] dd_step(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] t;
    t = acc;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (t[SR_W + 4*d +: 4] >= 4'd5) begin
          t[SR_W + 4*d +: 4] = t[SR_W + 4*d +: 4] + 4'd3;
        end
      end
      t = {t[ACC_W-2:0], 1'b0};
    end
    return t;
  endfunction

  assign out_valid    = (state_r == CV_DONE);
  assign out_item.neg = neg_r;
  assign out_item.bcd = acc_r[SR_W +: BCD_W];
  assign rd_en        = take && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    take      = 1'b0;
    unique case (state_r)
      CV_IDLE: begin
        take = 1'b1;
      end
      CV_RUN: begin
        acc_nxt = dd_step(acc_r);
        if (cnt_r == '0) begin
          state_nxt = CV_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      CV_DONE: begin
        if (out_ready) begin
          take      = 1'b1;
          state_nxt = CV_IDLE;
        end
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
    if (take && in_valid) begin
      acc_nxt   = {BCD_W'(0), SR_W'(in_item.mag)};
      neg_nxt   = in_item.neg;
      cnt_nxt   = STEP_CNT_W'(NUM_STEPS - 1);
      state_nxt = CV_RUN;
    end
  end

  `S2D_ASSERT(a_conv_finish, (state_r == CV_RUN && cnt_r == '0) |=> (state_r == CV_DONE), "Conversion did not finish after its last step.")

endmodule

// ----- hdl/s2d_emit.sv -----
// Character emitter: sign, then digits with leading zeros dropped, into an output register.
`include "signed_int_to_decimal_ascii_macros.svh"

module s2d_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  s2d_pkg::bcd_item_t             in_item,
  output logic                           in_ready,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [s2d_pkg::CHAR_W-1:0]     out_character,
  output logic                           out_last
);
  import s2d_pkg::*;

  emit_state_t          state_r, state_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [DIG_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 started_r, started_nxt;
  logic                 ov_r, ov_nxt;
  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic                 last_r, last_nxt;
  logic [3:0]           top;
  logic                 final_pos;
  logic                 room;

  assign top           = bcd_r[BCD_W-1 -: 4];
  assign final_pos     = (cnt_r == '0);
  assign room          = !ov_r || out_pop;
  assign out_empty     = !ov_r;
  assign out_character = ch_r;
  assign out_last      = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r     <= bcd_nxt;
    cnt_r     <= cnt_nxt;
    started_r <= started_nxt;
    ch_r      <= ch_nxt;
    last_r    <= last_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    ov_nxt      = ov_r && !out_pop;
    ch_nxt      = ch_r;
    last_nxt    = last_r;
    in_ready    = 1'b0;
    unique case (state_r)
      EM_IDLE: begin
        in_ready = 1'b1;
      end
      EM_SIGN: begin
        if (room) begin
          ov_nxt    = 1'b1;
          ch_nxt    = CHAR_MINUS;
          last_nxt  = 1'b0;
          state_nxt = EM_DIGITS;
        end
      end
      EM_DIGITS: begin
        if (top == 4'd0 && !started_r && !final_pos) begin
          bcd_nxt = bcd_r << 4;
          cnt_nxt = cnt_r - 1'b1;
        end else if (room) begin
          ov_nxt      = 1'b1;
          ch_nxt      = CHAR_ZERO + CHAR_W'(top);
          last_nxt    = final_pos;
          started_nxt = 1'b1;
          bcd_nxt     = bcd_r << 4;
          cnt_nxt     = cnt_r - 1'b1;
          if (final_pos) begin
            in_ready  = 1'b1;
            state_nxt = EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
    if (in_ready && in_valid) begin
      bcd_nxt     = in_item.bcd;
      cnt_nxt     = DIG_CNT_W'(NUM_DIGITS - 1);
      started_nxt = 1'b0;
      state_nxt   = in_item.neg ? EM_SIGN : EM_DIGITS;
    end
  end

  `S2D_ASSERT(a_emit_char_range, ov_r |-> (ch_r == CHAR_MINUS || (ch_r >= CHAR_ZERO && ch_r <= CHAR_NINE)), "Output character is neither a sign nor a digit.")
  `S2D_ASSERT(a_emit_sign_not_last, (ov_r && ch_r == CHAR_MINUS) |-> !last_r, "A minus sign was flagged as the last character.")
  `S2D_ASSERT_RST(a_emit_reset_empty, !rst_n |=> !ov_r, "Output register not empty after reset.")

endmodule
